// ===== hdl/atrp_pkg.sv =====
// Package for the accelerometer tilt block: widths, fixed-point constants,
// the CORDIC arctangent table and the angle output rounding.
// No dependencies.
package atrp_pkg;

  // Field widths
  localparam int RAW_W    = 16;
  localparam int SAMPLE_W = 14;
  localparam int ROLL_W   = 16;
  localparam int PITCH_W  = 15;

  // Angle formats
  localparam int ANGLE_FRACTION_BITS = 7;
  localparam int ACC_FRAC            = 16;
  localparam int ACC_W               = 26;
  localparam int ANG_SHIFT           = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam int QMAG_W              = ACC_W + 1 - ANG_SHIFT;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int XY_W         = 34;

  // Square root: radicand is (y^2 + z^2) followed by 2*ACC_FRAC zero bits,
  // two result bits per step
  localparam int SQ_IN_W   = 2 * SAMPLE_W;
  localparam int SQ_ROOT_W = (SQ_IN_W + 2 * ACC_FRAC) / 2;
  localparam int SQ_STEPS  = SQ_ROOT_W / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);

  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Handshake status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  localparam acc_t DEG90_ACC = ACC_W'(90 * (2 ** ACC_FRAC));

  localparam logic [QMAG_W-1:0] ROLL_LIM  = QMAG_W'(180 * (2 ** ANGLE_FRACTION_BITS));
  localparam logic [QMAG_W-1:0] PITCH_LIM = QMAG_W'(90 * (2 ** ANGLE_FRACTION_BITS));

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic acc_t atan_entry(input logic [STEP_W-1:0] idx);
    acc_t v;
    case (idx)
      5'd0:    v = ACC_W'(2949120);
      5'd1:    v = ACC_W'(1740967);
      5'd2:    v = ACC_W'(919879);
      5'd3:    v = ACC_W'(466945);
      5'd4:    v = ACC_W'(234379);
      5'd5:    v = ACC_W'(117304);
      5'd6:    v = ACC_W'(58666);
      5'd7:    v = ACC_W'(29335);
      5'd8:    v = ACC_W'(14668);
      5'd9:    v = ACC_W'(7334);
      5'd10:   v = ACC_W'(3667);
      5'd11:   v = ACC_W'(1833);
      5'd12:   v = ACC_W'(917);
      5'd13:   v = ACC_W'(458);
      5'd14:   v = ACC_W'(229);
      5'd15:   v = ACC_W'(115);
      5'd16:   v = ACC_W'(57);
      5'd17:   v = ACC_W'(29);
      5'd18:   v = ACC_W'(14);
      5'd19:   v = ACC_W'(7);
      5'd20:   v = ACC_W'(4);
      5'd21:   v = ACC_W'(2);
      5'd22:   v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round accumulator to output fraction bits (half away from zero), clamp
  function automatic logic signed [QMAG_W:0] to_output(input acc_t acc,
                                                       input logic [QMAG_W-1:0] lim);
    logic [ACC_W-1:0]  mag;
    logic [ACC_W:0]    rnd;
    logic [QMAG_W-1:0] q;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rnd = {1'b0, mag} + (ACC_W + 1)'(1 << (ANG_SHIFT - 1));
    q   = rnd[ACC_W:ANG_SHIFT];
    if (q > lim) begin
      q = lim;
    end
    return acc[ACC_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ===== hdl/atrp_isqrt.sv =====
// Iterative integer square root of n * 2^32, two result bits per cycle.
// Depends on atrp_pkg.
module atrp_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [atrp_pkg::SQ_IN_W-1:0]     n,
  output logic [atrp_pkg::SQ_ROOT_W-1:0]   root,
  output atrp_pkg::unit_status_t           stat
);

  localparam int REM_W = atrp_pkg::SQ_ROOT_W + 3;

  logic [atrp_pkg::SQ_IN_W-1:0]   rad;
  logic [REM_W-1:0]               rem;
  logic [atrp_pkg::SQ_CNT_W-1:0]  cnt;
  logic                           busy;
  logic                           done;
  logic [REM_W-1:0]               rem_next;
  logic [atrp_pkg::SQ_ROOT_W-1:0] root_next;
  logic [REM_W-1:0]               trial;

  assign stat.busy = busy;
  assign stat.done = done;

  // Two restoring steps: bring down a bit pair, compare against 4*root+1
  always_comb begin
    rem_next  = rem;
    root_next = root;
    trial     = '0;
    for (int k = 0; k < 2; k++) begin
      rem_next = {rem_next[REM_W-3:0], rad[atrp_pkg::SQ_IN_W-1-2*k -: 2]};
      trial    = {{(REM_W - atrp_pkg::SQ_ROOT_W - 2){1'b0}}, root_next, 2'b01};
      if (rem_next >= trial) begin
        rem_next  = rem_next - trial;
        root_next = {root_next[atrp_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        root_next = {root_next[atrp_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= n;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= rad << 4;
        rem  <= rem_next;
        root <= root_next;
        if (cnt == atrp_pkg::SQ_CNT_W'(atrp_pkg::SQ_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/atrp_cordic.sv =====
// Iterative CORDIC vectoring unit: atan2(num, den) in degrees * 2^16.
// One micro-rotation per cycle. Depends on atrp_pkg.
module atrp_cordic (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  atrp_pkg::xy_t          num,
  input  atrp_pkg::xy_t          den,
  output atrp_pkg::acc_t         angle,
  output atrp_pkg::unit_status_t stat
);

  atrp_pkg::xy_t               x;
  atrp_pkg::xy_t               y;
  atrp_pkg::acc_t              acc;
  logic [atrp_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  atrp_pkg::xy_t               dx;
  atrp_pkg::xy_t               dy;
  atrp_pkg::acc_t              tab;

  assign angle     = acc;
  assign stat.busy = busy;
  assign stat.done = done;

  // Shared shifter and table lookup for the current step
  assign dx  = y >>> cnt;
  assign dy  = x >>> cnt;
  assign tab = atrp_pkg::atan_entry(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (num == '0 && den == '0) begin
          // zero vector: angle is zero, no rotation
          acc  <= '0;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          if (den[atrp_pkg::XY_W-1]) begin
            // left half plane: turn by +-90 degrees first
            if (!num[atrp_pkg::XY_W-1]) begin
              x   <= num;
              y   <= -den;
              acc <= atrp_pkg::DEG90_ACC;
            end else begin
              x   <= -num;
              y   <= den;
              acc <= -atrp_pkg::DEG90_ACC;
            end
          end else begin
            x   <= den;
            y   <= num;
            acc <= '0;
          end
        end
      end else if (busy) begin
        // micro-rotation toward y = 0; zero residual counts as positive
        if (!y[atrp_pkg::XY_W-1]) begin
          x   <= x + dx;
          y   <= y - dy;
          acc <= acc + tab;
        end else begin
          x   <= x - dx;
          y   <= y + dy;
          acc <= acc - tab;
        end
        if (cnt == atrp_pkg::STEP_W'(atrp_pkg::CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/accel_tilt_roll_pitch.sv =====
// Top level: roll and pitch from one accelerometer sample, with reference hold.
// Depends on atrp_pkg, atrp_isqrt, atrp_cordic.
//
//   channel | signals                                           | handshake
//   --------+---------------------------------------------------+----------------------
//   input   | raw_x raw_y raw_z update_reference                | in_valid / in_stall
//   output  | roll_deg pitch_deg reference_roll reference_pitch | out_valid / out_stall
//
// A new item is taken only in the idle state, so the next item waits until the
// current result is loaded into the output register. The single CORDIC unit
// runs the roll pass, then the pitch pass; the square root runs beside the
// roll pass.
// Reset clears the sequencer, the result valid and both reference angles.
// A stalled result stays in its output register while the next item is taken;
// a finished item waits in the last state until that register is free.
module accel_tilt_roll_pitch (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [atrp_pkg::RAW_W-1:0]     raw_x,
  input  logic signed [atrp_pkg::RAW_W-1:0]     raw_y,
  input  logic signed [atrp_pkg::RAW_W-1:0]     raw_z,
  input  logic                                  update_reference,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [atrp_pkg::ROLL_W-1:0]    roll_deg,
  output logic signed [atrp_pkg::PITCH_W-1:0]   pitch_deg,
  output logic signed [atrp_pkg::ROLL_W-1:0]    reference_roll,
  output logic signed [atrp_pkg::PITCH_W-1:0]   reference_pitch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQY    = 3'd1;
  localparam logic [2:0] S_SQZ    = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_PSTART = 3'd4;
  localparam logic [2:0] S_PWAIT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam int SQ1_W = atrp_pkg::SQ_IN_W - 1;
  localparam int PAD_W = atrp_pkg::XY_W - atrp_pkg::SAMPLE_W - atrp_pkg::ACC_FRAC;

  logic [2:0]                                state;
  logic signed [atrp_pkg::SAMPLE_W-1:0]      sx;
  logic signed [atrp_pkg::SAMPLE_W-1:0]      sy;
  logic signed [atrp_pkg::SAMPLE_W-1:0]      sz;
  logic                                      upd;
  logic [SQ1_W-1:0]                          sq_y;
  logic                                      roll_ok;
  logic                                      root_ok;
  logic signed [atrp_pkg::ROLL_W-1:0]        roll_q;
  logic signed [atrp_pkg::PITCH_W-1:0]       pitch_q;

  logic signed [2*atrp_pkg::SAMPLE_W-1:0]    prod;
  logic [atrp_pkg::SQ_IN_W-1:0]              sq_sum;
  logic                                      cordic_start;
  atrp_pkg::xy_t                             cordic_num;
  atrp_pkg::xy_t                             cordic_den;
  atrp_pkg::acc_t                            cordic_angle;
  atrp_pkg::unit_status_t                    cordic_stat;
  logic [atrp_pkg::SQ_ROOT_W-1:0]            root;
  atrp_pkg::unit_status_t                    sqrt_stat;
  logic signed [atrp_pkg::QMAG_W:0]          roll_full;
  logic signed [atrp_pkg::QMAG_W:0]          pitch_full;
  logic                                      out_free;

  // Divide by 4, truncating toward zero
  function automatic logic signed [atrp_pkg::SAMPLE_W-1:0] div4(
      input logic signed [atrp_pkg::RAW_W-1:0] raw);
    logic signed [atrp_pkg::RAW_W:0] s;
    s = {raw[atrp_pkg::RAW_W-1], raw} + {{(atrp_pkg::RAW_W - 1){1'b0}},
                                         raw[atrp_pkg::RAW_W-1], raw[atrp_pkg::RAW_W-1]};
    return s[atrp_pkg::RAW_W-1:2];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Shared squarer: y*y in S_SQY, z*z in S_SQZ
  assign prod   = (state == S_SQY) ? sy * sy : sz * sz;
  assign sq_sum = {1'b0, sq_y} + {1'b0, prod[SQ1_W-1:0]};

  // CORDIC operands: roll pass atan2(y, z), pitch pass atan2(x, root)
  assign cordic_start = (state == S_SQY) || (state == S_PSTART);
  always_comb begin
    if (state == S_SQY) begin
      cordic_num = {{PAD_W{sy[atrp_pkg::SAMPLE_W-1]}}, sy, {atrp_pkg::ACC_FRAC{1'b0}}};
      cordic_den = {{PAD_W{sz[atrp_pkg::SAMPLE_W-1]}}, sz, {atrp_pkg::ACC_FRAC{1'b0}}};
    end else begin
      cordic_num = {{PAD_W{sx[atrp_pkg::SAMPLE_W-1]}}, sx, {atrp_pkg::ACC_FRAC{1'b0}}};
      cordic_den = {{(atrp_pkg::XY_W - atrp_pkg::SQ_ROOT_W){1'b0}}, root};
    end
  end

  assign roll_full  = atrp_pkg::to_output(cordic_angle, atrp_pkg::ROLL_LIM);
  assign pitch_full = atrp_pkg::to_output(cordic_angle, atrp_pkg::PITCH_LIM);

  atrp_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .num   (cordic_num),
    .den   (cordic_den),
    .angle (cordic_angle),
    .stat  (cordic_stat)
  );

  atrp_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQZ),
    .n     (sq_sum),
    .root  (root),
    .stat  (sqrt_stat)
  );

  // Sequencer, result capture and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      roll_ok         <= 1'b0;
      root_ok         <= 1'b0;
      out_valid       <= 1'b0;
      reference_roll  <= '0;
      reference_pitch <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cordic_stat.done && state != S_PWAIT) begin
        roll_q  <= roll_full[atrp_pkg::ROLL_W-1:0];
        roll_ok <= 1'b1;
      end
      if (sqrt_stat.done) begin
        root_ok <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sx      <= div4(raw_x);
            sy      <= div4(raw_y);
            sz      <= div4(raw_z);
            upd     <= update_reference;
            roll_ok <= 1'b0;
            root_ok <= 1'b0;
            state   <= S_SQY;
          end
        end
        S_SQY: begin
          sq_y  <= prod[SQ1_W-1:0];
          state <= S_SQZ;
        end
        S_SQZ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (roll_ok && root_ok) begin
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (cordic_stat.done) begin
            pitch_q <= pitch_full[atrp_pkg::PITCH_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            roll_deg  <= roll_q;
            pitch_deg <= pitch_q;
            out_valid <= 1'b1;
            if (upd) begin
              reference_roll  <= roll_q;
              reference_pitch <= pitch_q;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A taken result does not stay valid unless a new one is loaded
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && state != S_DONE |=> !out_valid)
    else $error("out_valid stayed high after transfer with no new result");

  // The CORDIC unit is only started when free
  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> !cordic_stat.busy)
    else $error("CORDIC started while busy");

  // The square root finishes while the sequencer waits for it
  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> state == S_WAIT)
    else $error("square root finished outside the wait state");

  // Both units are idle whenever a new sample can be taken
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !cordic_stat.busy && !sqrt_stat.busy)
    else $error("unit busy while sequencer idle");
`endif

endmodule
